FILE: rtl/binary_image_max_overlap_top_macros.svh
// assertion helpers used by bimo_back
`ifndef BINARY_IMAGE_MAX_OVERLAP_TOP_MACROS_SVH
`define BINARY_IMAGE_MAX_OVERLAP_TOP_MACROS_SVH

// property checked at every edge outside reset
`define BIMO_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BIMO_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) else $error(msg);

`endif

FILE: rtl/bimo_pkg.sv
package bimo_pkg;

	localparam int unsigned ROW_W  = 5;
	localparam int unsigned BITS_W = 32;
	localparam int unsigned SIM_W  = 11;

	// one row beat after classification
	typedef struct packed {
		logic              sel;
		logic              row_ok;
		logic [ROW_W-1:0]  row;
		logic [BITS_W-1:0] bits;
		logic              eop;
	} item_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RUN,
		ST_DRAIN,
		ST_EMIT
	} st_t;

endpackage

FILE: rtl/bimo_front.sv
module bimo_front
	import bimo_pkg::*;
#(
	parameter int unsigned SIZE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_sel,
	input  logic [ROW_W-1:0]  in_row,
	input  logic [BITS_W-1:0] in_bits,
	input  logic              in_eop,
	output logic              q_valid,
	output item_t             q_item,
	input  logic              q_pop
);

	item_t       slot_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	item_t       cls;
	logic        push;

	// rows beyond the grid are marked so the back part skips the store
	always_comb begin
		cls.sel    = in_sel;
		cls.row_ok = ({2'b00, in_row} < 7'(SIZE));
		cls.row    = in_row;
		cls.bits   = in_bits;
		cls.eop    = in_eop;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= cls;
	end

endmodule

FILE: rtl/bimo_back.sv
module bimo_back
	import bimo_pkg::*;
#(
	parameter int unsigned SIZE = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_pop,
	output logic             res_valid,
	output logic [SIM_W-1:0] res_data,
	input  logic             res_ready
);

`include "binary_image_max_overlap_top_macros.svh"

	localparam int unsigned RW = (SIZE > 1) ? $clog2(SIZE) : 1;
	localparam int unsigned KW = $clog2(2 * SIZE);
	localparam int unsigned CW = $clog2(SIZE + 1);
	localparam int unsigned TW = $clog2(SIZE * SIZE + 1);
	localparam int unsigned NG = (SIZE + 7) / 8;

	logic [SIZE-1:0] mov_q [SIZE];
	logic [SIZE-1:0] ref_q [SIZE];
	logic [SIZE-1:0] win_q [SIZE];

	st_t             st_q, st_d;
	logic [KW-1:0]   k_q, dxi_q;
	logic [2:0]      o_q;
	logic            run_last;

	logic [63:0]     bits_ext;
	logic [6:0]      row_ext;
	logic [SIZE-1:0] wbits;
	logic [RW-1:0]   wrow;

	logic            feed_on;
	logic [RW-1:0]   r, sy;
	logic [SIZE-1:0] mrow, orow, srow, feed;

	logic [CW-1:0]   rc_s1 [NG*8];
	logic [TW-1:0]   gs_s2 [NG];
	logic [TW-1:0]   tot_s3;
	logic            v_s1, v_s2, v_s3;
	logic [TW-1:0]   best_q;
	logic [TW+SIM_W-1:0] best_ext;

	assign bits_ext = {32'd0, q_item.bits};
	assign row_ext  = {2'b00, q_item.row};
	assign wbits    = bits_ext[SIZE-1:0];
	assign wrow     = row_ext[RW-1:0];

	// oriented row that enters the sliding window this cycle
	assign feed_on = (k_q < KW'(SIZE));
	assign r       = k_q[RW-1:0];
	assign sy      = o_q[1] ? (RW'(SIZE - 1) - r) : r;
	assign mrow    = mov_q[sy];

	always_comb begin
		for (int x = 0; x < SIZE; x++) begin
			if (!o_q[2]) orow[x] = o_q[0] ? mrow[SIZE-1-x] : mrow[x];
			else         orow[x] = o_q[0] ? mov_q[x][sy] : mov_q[SIZE-1-x][sy];
		end
		if (dxi_q >= KW'(SIZE)) srow = orow >> (dxi_q - KW'(SIZE));
		else                    srow = orow << (KW'(SIZE) - dxi_q);
		feed = feed_on ? srow : '0;
	end

	assign run_last = (k_q == KW'(2 * SIZE - 1)) && (dxi_q == KW'(2 * SIZE - 1)) &&
		(o_q == 3'd7);

	always_comb begin
		st_d      = st_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		unique case (st_q)
			ST_LOAD: begin
				q_pop = q_valid;
				if (q_valid && q_item.eop) st_d = ST_RUN;
			end
			ST_RUN: begin
				if (run_last) st_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) st_d = ST_EMIT;
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) st_d = ST_LOAD;
			end
			default: st_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_LOAD;
			k_q   <= '0;
			dxi_q <= '0;
			o_q   <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			best_q <= '0;
			for (int y = 0; y < SIZE; y++) begin
				mov_q[y] <= '0;
				ref_q[y] <= '0;
				win_q[y] <= '0;
			end
		end else begin
			st_q <= st_d;
			v_s1 <= (st_q == ST_RUN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3 && tot_s3 > best_q) best_q <= tot_s3;
			if (q_pop) begin
				if (q_item.row_ok) begin
					if (q_item.sel) ref_q[wrow] <= wbits;
					else            mov_q[wrow] <= wbits;
				end
				if (q_item.eop) begin
					k_q    <= '0;
					dxi_q  <= '0;
					o_q    <= '0;
					best_q <= '0;
					for (int y = 0; y < SIZE; y++) win_q[y] <= '0;
				end
			end
			if (st_q == ST_RUN) begin
				for (int y = 0; y < SIZE - 1; y++) win_q[y] <= win_q[y+1];
				win_q[SIZE-1] <= feed;
				if (k_q == KW'(2 * SIZE - 1)) begin
					k_q <= '0;
					if (dxi_q == KW'(2 * SIZE - 1)) begin
						dxi_q <= '0;
						o_q   <= o_q + 3'd1;
					end else begin
						dxi_q <= dxi_q + KW'(1);
					end
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			if (res_valid && res_ready) begin
				for (int y = 0; y < SIZE; y++) begin
					mov_q[y] <= '0;
					ref_q[y] <= '0;
				end
			end
		end
	end

	// score pipeline: row counts, groups of eight, total
	always_ff @(posedge clk) begin
		for (int y = 0; y < NG * 8; y++) begin
			if (y < SIZE) rc_s1[y] <= CW'($countones(ref_q[y] & win_q[y]));
			else          rc_s1[y] <= '0;
		end
		for (int g = 0; g < NG; g++) begin
			gs_s2[g] <= TW'(rc_s1[g*8]) + TW'(rc_s1[g*8+1]) + TW'(rc_s1[g*8+2]) +
				TW'(rc_s1[g*8+3]) + TW'(rc_s1[g*8+4]) + TW'(rc_s1[g*8+5]) +
				TW'(rc_s1[g*8+6]) + TW'(rc_s1[g*8+7]);
		end
	end

	always_ff @(posedge clk) begin
		logic [TW-1:0] acc;
		acc = '0;
		for (int g = 0; g < NG; g++) acc = acc + gs_s2[g];
		tot_s3 <= acc;
	end

	assign best_ext = {{SIM_W{1'b0}}, best_q};
	assign res_data = best_ext[SIM_W-1:0];

	`BIMO_CHK(a_pop_only_load, q_pop |-> (st_q == ST_LOAD), "row taken while scoring")
	`BIMO_CHK(a_best_bound, best_q <= TW'(SIZE * SIZE), "overlap above pixel count")
	`BIMO_NEXT(a_clear_after, res_valid && res_ready,
		(ref_q[0] == '0) && (mov_q[0] == '0) && (st_q == ST_LOAD), "stores not cleared")
	`BIMO_NEXT(a_run_holds, (st_q == ST_RUN) && !run_last, st_q == ST_RUN,
		"scan left early")

endmodule

FILE: rtl/binary_image_max_overlap_top.sv
// Binary image max overlap: rows of a moving image (tuser 0) and a reference image
// (tuser 1) arrive one row per beat; the beat with tlast set is stored and then
// closes the pair, and one similarity beat later comes out on m_axis. Ordinary row
// beats are taken at one per cycle through a two-entry queue while the back part is
// loading; during a scan the queue fills and holds the input. The closing beat starts
// a scan of 8 orientations x 2*SIZE shifts in x x 2*SIZE shifts in y, one placement
// per cycle, scored through a sliding row window and a full-image popcount pipeline.
// Both images are cleared when the result is handed over.
module binary_image_max_overlap_top
	import bimo_pkg::*;
#(
	parameter int unsigned SIZE = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // row_index [4:0], row_bits [36:5], zero pad
	input  logic        s_axis_tuser,  // image_select
	input  logic        s_axis_tlast,  // end_of_pair
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // similarity [10:0], zero pad
);

	logic             q_valid;
	item_t            q_item;
	logic             q_pop;
	logic             res_valid;
	logic [SIM_W-1:0] res_data;
	logic             res_ready;
	logic             out_valid_q;
	logic [SIM_W-1:0] out_data_q;

	// front: takes beats, flags out-of-grid rows, queues them
	bimo_front #(.SIZE(SIZE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_sel   (s_axis_tuser),
		.in_row   (s_axis_tdata[4:0]),
		.in_bits  (s_axis_tdata[36:5]),
		.in_eop   (s_axis_tlast),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back: image stores and placement scan
	bimo_back #(.SIZE(SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	// output register, frees the back part while the result waits
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) out_data_q <= res_data;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(16 - SIM_W){1'b0}}, out_data_q};

endmodule
